[rtl/core/pps_pkg.sv]
// shared types and constants for the particle pool stepper
package pps_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CfgColorStart = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgColorEnd   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeStart  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSizeEnd    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLifeSpan   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSpeed      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgGravity    = 3'd6;

  localparam logic FuncTick = 1'b0;
  localparam logic FuncEmit = 1'b1;

  typedef struct packed {
    logic               func;
    logic [15:0]        step_seconds;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
    logic signed [31:0] place_z;
    logic [31:0]        tint;
    logic [15:0]        extent;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] tint_from;
    logic [31:0] tint_to;
    logic [15:0] extent_from;
    logic [15:0] extent_to;
    logic [30:0] life_span;
    logic [30:0] launch_speed;
    logic [47:0] gravity_accel;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture accepted transaction
    logic emit_wr;   // write a new particle into scan_slot
    logic rd;        // read memories at scan_slot
    logic div_start; // start life/life_span division on read data
    logic upd;       // write back updated slot, fill output register
    logic mark_last; // set last flag on the held output
    logic out_pop;   // output taken
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic out_full;
    logic live_sel;  // liveness of the slot under scan (flip-flop)
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -49'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [16:0] t);
    logic [25:0] r;
    r = 26'(a) * 26'(17'd65536 - t) + 26'(b) * 26'(t) + 26'd32768;
    return r[23:16];
  endfunction

  function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                         input logic [16:0] t);
    logic [33:0] r;
    r = 34'(a) * 34'(17'd65536 - t) + 34'(b) * 34'(t) + 34'd32768;
    return r[31:16];
  endfunction

endpackage

[rtl/core/pps_divider.sv]
// radix-2 restoring divider for the life fraction (life << 16) / life_span
module pps_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] life_i,
  input  logic [30:0] span_i,
  output logic        busy_o,
  output logic [16:0] t_o
);
  // numerator is 48 bits; quotient saturates past 2^16 so we only care
  // whether it reaches 65536. the first 31 steps and quotient bit 16 decide that.
  logic [47:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [16:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        sat_q, sat_d;
  logic [30:0] span_q;
  logic [32:0] trial;

  assign trial = {rem_q, num_q[47]} - {2'b0, span_q};

  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; sat_d = sat_q;
    if (start_i) begin
      num_d = {life_i, 16'd0};
      rem_d = '0;
      quo_d = '0;
      cnt_d = 6'd48;
      busy_d = (span_i != '0);
      sat_d = 1'b0;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        if (cnt_q > 6'd17) sat_d = 1'b1;
        else quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], num_q[47]};
        if (cnt_q <= 6'd17) quo_d = {quo_q[15:0], 1'b0};
      end
      num_d = {num_q[46:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; sat_q <= sat_d;
    if (start_i) span_q <= span_i;
  end

  // span zero -> t 0; quotient >= 65536 -> t 0
  logic zero_q;
  always_ff @(posedge clk_i) if (start_i) zero_q <= (span_i == '0);

  assign busy_o = busy_q;
  assign t_o = (zero_q || sat_q || quo_q[16]) ? 17'd0 : 17'd65536 - quo_q;
endmodule

[rtl/core/pps_datapath.sv]
// particle storage, arithmetic and output register
module pps_datapath #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pps_pkg::cfg_t         cfg_i,
  input  pps_pkg::in_item_t     item_i,
  input  logic [5:0]            scan_slot_i,
  input  pps_pkg::dp_cmd_t      cmd_i,
  output pps_pkg::dp_sts_t      sts_o,
  output pps_pkg::out_item_t    out_o
);
  import pps_pkg::*;

  localparam int unsigned IdxW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  logic [IdxW-1:0] idx;
  assign idx = scan_slot_i[IdxW-1:0];

  in_item_t item_q;
  always_ff @(posedge clk_i) if (cmd_i.load) item_q <= item_i;

  // position and velocity memories; life also mirrored by live flags
  logic signed [31:0] px_m [POOL_SIZE];
  logic signed [31:0] py_m [POOL_SIZE];
  logic signed [31:0] pz_m [POOL_SIZE];
  logic signed [31:0] vx_m [POOL_SIZE];
  logic signed [31:0] vy_m [POOL_SIZE];
  logic signed [31:0] vz_m [POOL_SIZE];
  logic signed [31:0] life_m [POOL_SIZE];
  logic [POOL_SIZE-1:0] live_q;

  logic signed [31:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r, life_r;
  logic [5:0] slot_r;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      px_r <= px_m[idx]; py_r <= py_m[idx]; pz_r <= pz_m[idx];
      vx_r <= vx_m[idx]; vy_r <= vy_m[idx]; vz_r <= vz_m[idx];
      life_r <= life_m[idx];
      slot_r <= scan_slot_i;
    end
  end

  // emit velocity
  logic signed [47:0] ex, ey, ez;
  logic signed [31:0] spd;
  assign spd = {1'b0, cfg_i.launch_speed};
  assign ex = (48'(item_q.dir_x) * 48'(spd)) >>> 14;
  assign ey = (48'(item_q.dir_y) * 48'(spd)) >>> 14;
  assign ez = (48'(item_q.dir_z) * 48'(spd)) >>> 14;

  // tick arithmetic
  logic signed [16:0] dt;
  assign dt = {1'b0, item_q.step_seconds};
  logic signed [48:0] mx, my, mz;
  assign mx = (49'(vx_r) * 49'(dt)) >>> 16;
  assign my = (49'(vy_r) * 49'(dt)) >>> 16;
  assign mz = (49'(vz_r) * 49'(dt)) >>> 16;
  logic signed [31:0] npx, npy, npz;
  assign npx = px_r + mx[31:0];
  assign npy = py_r + my[31:0];
  assign npz = pz_r + mz[31:0];

  logic signed [15:0] ax, ay, az;
  assign ax = cfg_i.gravity_accel[47:32];
  assign ay = cfg_i.gravity_accel[31:16];
  assign az = cfg_i.gravity_accel[15:0];
  logic signed [32:0] gx, gy, gz;
  assign gx = (33'(ax) * 33'(dt)) >>> 8;
  assign gy = (33'(ay) * 33'(dt)) >>> 8;
  assign gz = (33'(az) * 33'(dt)) >>> 8;
  logic signed [31:0] nvx, nvy, nvz, nlife;
  assign nvx = sat32(49'(vx_r) + 49'(gx));
  assign nvy = sat32(49'(vy_r) + 49'(gy));
  assign nvz = sat32(49'(vz_r) + 49'(gz));
  assign nlife = life_r - 32'(dt);

  logic [16:0] t;
  logic div_busy;
  pps_divider u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .life_i (life_r),
    .span_i (cfg_i.life_span),
    .busy_o (div_busy),
    .t_o    (t)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_wr) begin
      px_m[idx] <= item_q.origin_x;
      py_m[idx] <= item_q.origin_y;
      pz_m[idx] <= item_q.origin_z;
      vx_m[idx] <= sat32(49'(ex));
      vy_m[idx] <= sat32(49'(ey));
      vz_m[idx] <= sat32(49'(ez));
      life_m[idx] <= {1'b0, cfg_i.life_span};
    end else if (cmd_i.upd) begin
      px_m[slot_r[IdxW-1:0]] <= npx;
      py_m[slot_r[IdxW-1:0]] <= npy;
      pz_m[slot_r[IdxW-1:0]] <= npz;
      vx_m[slot_r[IdxW-1:0]] <= nvx;
      vy_m[slot_r[IdxW-1:0]] <= nvy;
      vz_m[slot_r[IdxW-1:0]] <= nvz;
      life_m[slot_r[IdxW-1:0]] <= nlife;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (cmd_i.emit_wr) begin
      live_q[idx] <= (cfg_i.life_span != '0);
    end else if (cmd_i.upd) begin
      live_q[slot_r[IdxW-1:0]] <= (nlife > 0);
    end
  end

  // output register
  out_item_t out_q;
  logic full_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (cmd_i.upd) full_q <= 1'b1;
    else if (cmd_i.out_pop) full_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      out_q.slot <= slot_r;
      out_q.place_x <= npx;
      out_q.place_y <= npy;
      out_q.place_z <= npz;
      out_q.tint <= {lerp8(cfg_i.tint_from[31:24], cfg_i.tint_to[31:24], t),
                     lerp8(cfg_i.tint_from[23:16], cfg_i.tint_to[23:16], t),
                     lerp8(cfg_i.tint_from[15:8],  cfg_i.tint_to[15:8],  t),
                     lerp8(cfg_i.tint_from[7:0],   cfg_i.tint_to[7:0],   t)};
      out_q.extent <= lerp16(cfg_i.extent_from, cfg_i.extent_to, t);
      out_q.last <= 1'b0;
    end else if (cmd_i.mark_last) begin
      out_q.last <= 1'b1;
    end
  end

  assign out_o = out_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_full = full_q;
  assign sts_o.live_sel = live_q[idx];
endmodule

[rtl/core/pps_ctrl.sv]
// sequencer: slot scan for emit and tick, divider wait, output handshake
module pps_ctrl #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_func_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [5:0]       scan_slot_o,
  output pps_pkg::dp_cmd_t cmd_o,
  input  pps_pkg::dp_sts_t sts_i
);
  import pps_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEmit = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StRead = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;

  localparam logic [6:0] Last = 7'(POOL_SIZE - 1);

  logic [2:0] st_q, st_d;
  logic [6:0] slot_q, slot_d;
  logic       any_q, any_d;  // a result is held that may still be the last
  logic       pop;

  // a held result goes out once another live slot is found; the final one
  // waits in StFin for its last flag
  assign out_valid_o = sts_i.out_full &&
                       !(any_q && (st_q == StScan || st_q == StFin));
  assign pop = out_valid_o && !out_stall_i;
  assign scan_slot_o = slot_q[5:0];
  assign in_stall_o = (st_q != StIdle);

  always_comb begin
    st_d = st_q; slot_d = slot_q; any_d = any_q;
    cmd_o = '0;
    cmd_o.out_pop = pop;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          slot_d = '0;
          any_d = 1'b0;
          st_d = (in_func_i == FuncEmit) ? StEmit : StScan;
        end
      end
      StEmit: begin
        if (!sts_i.live_sel) begin
          cmd_o.emit_wr = 1'b1;
          st_d = StIdle;
        end else if (slot_q == Last) begin
          st_d = StIdle;
        end else begin
          slot_d = slot_q + 7'd1;
        end
      end
      StScan: begin
        if (sts_i.live_sel) begin
          cmd_o.rd = 1'b1;
          st_d = StRead;
        end else if (slot_q == Last) begin
          st_d = StFin;
        end else begin
          slot_d = slot_q + 7'd1;
        end
      end
      StRead: begin
        cmd_o.div_start = 1'b1;
        st_d = StDiv;
      end
      StDiv: begin
        // previous result must be gone before overwriting it
        if (!sts_i.div_busy && (!sts_i.out_full || pop)) st_d = StOut;
      end
      StOut: begin
        cmd_o.upd = 1'b1;
        any_d = 1'b1;
        if (slot_q == Last) st_d = StFin;
        else begin
          slot_d = slot_q + 7'd1;
          st_d = StScan;
        end
      end
      StFin: begin
        if (any_q && sts_i.out_full && !pop) cmd_o.mark_last = 1'b1;
        any_d = 1'b0;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      slot_q <= '0;
      any_q <= 1'b0;
    end else begin
      st_q <= st_d;
      slot_q <= slot_d;
      any_q <= any_d;
    end
  end
endmodule

[rtl/core/particle_pool_step_top.sv]
// Particle pool stepper top level. One transaction at a time: an emit scans
// the slots up to the first free one; a tick scans every slot and, for each
// live particle, waits on the bit-serial divider that forms life/life_span
// for the color and size blend, plus any wait for the previous result to
// leave. A tick result is held until it is known whether another live slot
// follows, so each result appears once the next live slot or the end of the
// pool is reached; the last one carries last. The input is stalled while a
// transaction is in progress.
module particle_pool_step_top #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pps_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pps_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pps_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pps_pkg::out_item_t                out_data_o
);
  import pps_pkg::*;

  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tint_from <= 32'hFFFF_FFFF;
      cfg_q.tint_to <= '0;
      cfg_q.extent_from <= 16'd256;
      cfg_q.extent_to <= '0;
      cfg_q.life_span <= 31'd65536;
      cfg_q.launch_speed <= 31'd65536;
      cfg_q.gravity_accel <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgColorStart: cfg_q.tint_from <= cfg_data_i[31:0];
        CfgColorEnd:   cfg_q.tint_to <= cfg_data_i[31:0];
        CfgSizeStart:  cfg_q.extent_from <= cfg_data_i[15:0];
        CfgSizeEnd:    cfg_q.extent_to <= cfg_data_i[15:0];
        CfgLifeSpan:   cfg_q.life_span <= cfg_data_i[30:0];
        CfgSpeed:      cfg_q.launch_speed <= cfg_data_i[30:0];
        CfgGravity:    cfg_q.gravity_accel <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [5:0] scan_slot;

  pps_ctrl #(.POOL_SIZE(POOL_SIZE)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_func_i  (in_data_i.func),
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .scan_slot_o(scan_slot),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pps_datapath #(.POOL_SIZE(POOL_SIZE)) u_dp (
    .clk_i, .rst_ni,
    .cfg_i      (cfg_q),
    .item_i     (in_data_i),
    .scan_slot_i(scan_slot),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_data_o)
  );
endmodule
